// File: rtl/qlfo_pkg.sv
// Shared types and constants for the quadrature LFO envelope block.
`timescale 1ns / 1ps
`default_nettype none

package qlfo_pkg;

    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 30;
    localparam int LANES    = 8;
    localparam int PAIRS    = 4;
    localparam int FLAG_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic signed [PHASE_W-1:0] PHASE_X_RESET = 32'sd759250125;
    localparam logic signed [PHASE_W-1:0] PHASE_Y_RESET = -32'sd759250125;
    localparam logic signed [PHASE_W-1:0] ROT_COS_RESET = 32'sd1073741824;
    localparam logic signed [PHASE_W-1:0] ROT_SIN_RESET = 32'sd0;

    typedef enum logic [1:0] {
        CMD_OSC  = 2'd0,
        CMD_ENV  = 2'd1,
        CMD_LOAD = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_COS = 1'b0,
        REG_ROT_SIN = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic fire;
        cmd_t cmd;
    } rot_ctl_t;

    typedef struct packed {
        logic adv_a;
        logic adv_b;
    } lane_ctl_t;

endpackage

`default_nettype wire

// File: rtl/quadrature_lfo_envelope.sv
// Top level: quadrature LFO with eight-lane stereo envelope and output register.
`timescale 1ns / 1ps
`default_nettype none

// Coupled-form quadrature oscillator with a four-pair stereo envelope. One
// transaction is accepted every clock cycle unless m_ready stalls; its result
// passes the lane and output registers. The phase rotation (four 32x32
// multiplies, sum, round and saturate) is combinational on the phase registers,
// so consecutive transactions see each other's rotation without a bubble. Eight
// scaling lanes multiply the channel samples by the pre-rotation gains in the
// first stage and round and saturate in the second, which is the output
// register. Coefficients are written through cfg_we/cfg_idx/cfg_wdata and take
// effect on the next accepted transaction; write them only while the block is
// idle. No transaction is accepted while reset is held.
module quadrature_lfo_envelope
    import qlfo_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_idx,
    input  wire logic [PHASE_W-1:0]          cfg_wdata,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_cmd,
    input  wire logic signed [SAMPLE_W-1:0]  s_in_l0,
    input  wire logic signed [SAMPLE_W-1:0]  s_in_l1,
    input  wire logic signed [SAMPLE_W-1:0]  s_in_l2,
    input  wire logic signed [SAMPLE_W-1:0]  s_in_l3,
    input  wire logic signed [SAMPLE_W-1:0]  s_in_r0,
    input  wire logic signed [SAMPLE_W-1:0]  s_in_r1,
    input  wire logic signed [SAMPLE_W-1:0]  s_in_r2,
    input  wire logic signed [SAMPLE_W-1:0]  s_in_r3,
    input  wire logic signed [PHASE_W-1:0]   s_load_x,
    input  wire logic signed [PHASE_W-1:0]   s_load_y,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]       m_out_l0,
    output logic signed [SAMPLE_W-1:0]       m_out_l1,
    output logic signed [SAMPLE_W-1:0]       m_out_l2,
    output logic signed [SAMPLE_W-1:0]       m_out_l3,
    output logic signed [SAMPLE_W-1:0]       m_out_r0,
    output logic signed [SAMPLE_W-1:0]       m_out_r1,
    output logic signed [SAMPLE_W-1:0]       m_out_r2,
    output logic signed [SAMPLE_W-1:0]       m_out_r3,
    output logic signed [PHASE_W-1:0]        m_osc_r,
    output logic signed [PHASE_W-1:0]        m_osc_q,
    output logic [FLAG_W-1:0]                m_active_flags
);

    logic a_valid_reg, a_valid_next;
    logic m_valid_reg, m_valid_next;
    lane_ctl_t lane_ctl;
    rot_ctl_t  rot_ctl;
    cmd_t      cmd;

    logic signed [PHASE_W-1:0] phase_x, phase_y;
    logic [FLAG_W-1:0]         flags;
    logic signed [PHASE_W-1:0] gain [PAIRS];
    logic signed [SAMPLE_W-1:0] samples [LANES];
    logic signed [SAMPLE_W-1:0] results [LANES];

    logic signed [PHASE_W-1:0] osc_r_a_reg, osc_q_a_reg;
    logic [FLAG_W-1:0]         flags_a_reg;
    logic signed [PHASE_W-1:0] osc_r_reg, osc_q_reg;
    logic [FLAG_W-1:0]         flags_reg;

    assign cmd            = cmd_t'(s_cmd);
    assign lane_ctl.adv_b = !m_valid_reg || m_ready;
    assign lane_ctl.adv_a = !a_valid_reg || lane_ctl.adv_b;
    assign s_ready        = lane_ctl.adv_a && aresetn;
    assign rot_ctl.fire   = s_valid && s_ready;
    assign rot_ctl.cmd    = cmd;

    always_comb begin
        a_valid_next = lane_ctl.adv_a ? s_valid : a_valid_reg;
        m_valid_next = lane_ctl.adv_b ? a_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (lane_ctl.adv_a) begin
            osc_r_a_reg <= phase_x;
            osc_q_a_reg <= phase_y;
            flags_a_reg <= flags;
        end
        if (lane_ctl.adv_b) begin
            osc_r_reg <= osc_r_a_reg;
            osc_q_reg <= osc_q_a_reg;
            flags_reg <= flags_a_reg;
        end
    end

    qlfo_rot u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .ctl       (rot_ctl),
        .load_x    (s_load_x),
        .load_y    (s_load_y),
        .phase_x   (phase_x),
        .phase_y   (phase_y),
        .flags     (flags)
    );

    // Zero gain outside envelope transactions forces the lane outputs to zero.
    always_comb begin
        if (cmd == CMD_ENV) begin
            gain[0] = (phase_x > 0) ? phase_x : '0;
            gain[1] = (phase_x < 0) ? phase_x : '0;
            gain[2] = (phase_y > 0) ? phase_y : '0;
            gain[3] = (phase_y < 0) ? phase_y : '0;
        end else begin
            gain[0] = '0;
            gain[1] = '0;
            gain[2] = '0;
            gain[3] = '0;
        end
    end

    assign samples[0] = s_in_l0;
    assign samples[1] = s_in_l1;
    assign samples[2] = s_in_l2;
    assign samples[3] = s_in_l3;
    assign samples[4] = s_in_r0;
    assign samples[5] = s_in_r1;
    assign samples[6] = s_in_r2;
    assign samples[7] = s_in_r3;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        qlfo_lane u_lane (
            .aclk   (aclk),
            .ctl    (lane_ctl),
            .sample (samples[k]),
            .gain   (gain[k % PAIRS]),
            .result (results[k])
        );
    end

    assign m_valid        = m_valid_reg;
    assign m_out_l0       = results[0];
    assign m_out_l1       = results[1];
    assign m_out_l2       = results[2];
    assign m_out_l3       = results[3];
    assign m_out_r0       = results[4];
    assign m_out_r1       = results[5];
    assign m_out_r2       = results[6];
    assign m_out_r3       = results[7];
    assign m_osc_r        = osc_r_reg;
    assign m_osc_q        = osc_q_reg;
    assign m_active_flags = flags_reg;

endmodule

`default_nettype wire

// File: rtl/qlfo_lane.sv
// One envelope lane: sample times gain, then round to Q1.23 and saturate.
`timescale 1ns / 1ps
`default_nettype none

module qlfo_lane
    import qlfo_pkg::*;
(
    input  wire logic                       aclk,
    input  wire lane_ctl_t                  ctl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [PHASE_W-1:0]  gain,
    output logic signed [SAMPLE_W-1:0]      result
);

    localparam int PROD_W = SAMPLE_W + PHASE_W;
    localparam int Q_W    = PROD_W + 1 - FRAC_W;
    localparam logic signed [PROD_W:0] HALF = (PROD_W+1)'(64'd1 << (FRAC_W - 1));
    localparam logic signed [Q_W-1:0] S_MAX = Q_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] S_MIN = Q_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W:0]     biased;
    logic signed [Q_W-1:0]      quot;
    logic signed [SAMPLE_W-1:0] result_next;
    logic signed [SAMPLE_W-1:0] result_reg;

    always_ff @(posedge aclk) begin
        if (ctl.adv_a) begin
            prod_reg <= PROD_W'(sample) * PROD_W'(gain);
        end
        if (ctl.adv_b) begin
            result_reg <= result_next;
        end
    end

    always_comb begin
        biased = {prod_reg[PROD_W-1], prod_reg} + HALF;
        quot   = biased[PROD_W:FRAC_W];
        if (quot > S_MAX) begin
            result_next = S_MAX[SAMPLE_W-1:0];
        end else if (quot < S_MIN) begin
            result_next = S_MIN[SAMPLE_W-1:0];
        end else begin
            result_next = quot[SAMPLE_W-1:0];
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/qlfo_rot.sv
// Rotation coefficients, phase vector state and the combinational rotation.
`timescale 1ns / 1ps
`default_nettype none

module qlfo_rot
    import qlfo_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_idx,
    input  wire logic [PHASE_W-1:0]          cfg_wdata,
    input  wire rot_ctl_t                    ctl,
    input  wire logic signed [PHASE_W-1:0]   load_x,
    input  wire logic signed [PHASE_W-1:0]   load_y,
    output logic signed [PHASE_W-1:0]        phase_x,
    output logic signed [PHASE_W-1:0]        phase_y,
    output logic [FLAG_W-1:0]                flags
);

    localparam int MUL_W = 2 * PHASE_W;
    localparam int SUM_W = MUL_W + 1;
    localparam int Q_W   = SUM_W - FRAC_W;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'd1 << (FRAC_W - 1));
    localparam logic signed [Q_W-1:0] P_MAX = Q_W'((64'sd1 <<< (PHASE_W - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] P_MIN = Q_W'(-(64'sd1 <<< (PHASE_W - 1)));

    logic signed [PHASE_W-1:0] rot_cos_reg;
    logic signed [PHASE_W-1:0] rot_sin_reg;
    logic signed [PHASE_W-1:0] phase_x_reg;
    logic signed [PHASE_W-1:0] phase_y_reg;
    logic signed [PHASE_W-1:0] phase_x_next;
    logic signed [PHASE_W-1:0] phase_y_next;

    logic signed [MUL_W-1:0] cx, sy, sx, cy;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [Q_W-1:0]   q_x, q_y;
    logic signed [PHASE_W-1:0] rot_x, rot_y;

    function automatic logic signed [PHASE_W-1:0] sat_phase(input logic signed [Q_W-1:0] q);
        logic signed [PHASE_W-1:0] r;
        if (q > P_MAX) begin
            r = P_MAX[PHASE_W-1:0];
        end else if (q < P_MIN) begin
            r = P_MIN[PHASE_W-1:0];
        end else begin
            r = q[PHASE_W-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_cos_reg <= ROT_COS_RESET;
            rot_sin_reg <= ROT_SIN_RESET;
            phase_x_reg <= PHASE_X_RESET;
            phase_y_reg <= PHASE_Y_RESET;
        end else begin
            if (cfg_we) begin
                unique case (reg_idx_t'(cfg_idx))
                    REG_ROT_COS: rot_cos_reg <= cfg_wdata;
                    REG_ROT_SIN: rot_sin_reg <= cfg_wdata;
                endcase
            end
            phase_x_reg <= phase_x_next;
            phase_y_reg <= phase_y_next;
        end
    end

    always_comb begin
        cx    = MUL_W'(rot_cos_reg) * MUL_W'(phase_x_reg);
        sy    = MUL_W'(rot_sin_reg) * MUL_W'(phase_y_reg);
        sx    = MUL_W'(rot_sin_reg) * MUL_W'(phase_x_reg);
        cy    = MUL_W'(rot_cos_reg) * MUL_W'(phase_y_reg);
        sum_x = {cx[MUL_W-1], cx} - {sy[MUL_W-1], sy} + HALF;
        sum_y = {sx[MUL_W-1], sx} + {cy[MUL_W-1], cy} + HALF;
        q_x   = sum_x[SUM_W-1:FRAC_W];
        q_y   = sum_y[SUM_W-1:FRAC_W];
        rot_x = sat_phase(q_x);
        rot_y = sat_phase(q_y);

        phase_x_next = phase_x_reg;
        phase_y_next = phase_y_reg;
        if (ctl.fire) begin
            unique case (ctl.cmd)
                CMD_OSC, CMD_ENV: begin
                    phase_x_next = rot_x;
                    phase_y_next = rot_y;
                end
                CMD_LOAD: begin
                    phase_x_next = load_x;
                    phase_y_next = load_y;
                end
                default: begin
                    phase_x_next = phase_x_reg;
                    phase_y_next = phase_y_reg;
                end
            endcase
        end

        if (ctl.cmd == CMD_ENV) begin
            flags = {rot_y < 0, rot_y > 0, rot_x < 0, rot_x > 0};
        end else begin
            flags = '0;
        end
    end

    assign phase_x = phase_x_reg;
    assign phase_y = phase_y_reg;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the quadrature LFO envelope block.
`timescale 1ns / 1ps

module testbench
    import qlfo_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
    localparam logic signed [31:0] Q30_MINUS_ONE = -32'sd1073741824;
    localparam logic signed [23:0] SAMPLE_MAX = 24'sd8388607;
    localparam logic signed [23:0] SAMPLE_MIN = -24'sd8388608;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [3:0][23:0]  l;
        logic [3:0][23:0]  r;
        logic [31:0]       lx;
        logic [31:0]       ly;
    } lfo_frame_t;

    typedef struct packed {
        logic [3:0][23:0]  l;
        logic [3:0][23:0]  r;
        logic [31:0]       osc_r;
        logic [31:0]       osc_q;
        logic [3:0]        flags;
    } lfo_result_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [PHASE_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_cmd;
    logic signed [SAMPLE_W-1:0] s_in_l0, s_in_l1, s_in_l2, s_in_l3;
    logic signed [SAMPLE_W-1:0] s_in_r0, s_in_r1, s_in_r2, s_in_r3;
    logic signed [PHASE_W-1:0] s_load_x, s_load_y;
    logic m_valid;
    logic m_ready;
    logic signed [SAMPLE_W-1:0] m_out_l0, m_out_l1, m_out_l2, m_out_l3;
    logic signed [SAMPLE_W-1:0] m_out_r0, m_out_r1, m_out_r2, m_out_r3;
    logic signed [PHASE_W-1:0] m_osc_r, m_osc_q;
    logic [FLAG_W-1:0] m_active_flags;

    logic signed [31:0] coef_cos, coef_sin;
    logic signed [31:0] phase_x, phase_y;
    lfo_result_t due_results[$];
    int mismatches;
    int stall_pct;
    int cycle_count;

    quadrature_lfo_envelope DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_in_l0(s_in_l0), .s_in_l1(s_in_l1), .s_in_l2(s_in_l2), .s_in_l3(s_in_l3),
        .s_in_r0(s_in_r0), .s_in_r1(s_in_r1), .s_in_r2(s_in_r2), .s_in_r3(s_in_r3),
        .s_load_x(s_load_x), .s_load_y(s_load_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_l0(m_out_l0), .m_out_l1(m_out_l1), .m_out_l2(m_out_l2), .m_out_l3(m_out_l3),
        .m_out_r0(m_out_r0), .m_out_r1(m_out_r1), .m_out_r2(m_out_r2), .m_out_r3(m_out_r3),
        .m_osc_r(m_osc_r), .m_osc_q(m_osc_q), .m_active_flags(m_active_flags)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Round half up from Q30 and clamp to 32 bits.
    function automatic logic signed [31:0] q30_to_phase(input logic signed [65:0] acc);
        logic signed [65:0] q;
        q = (acc + 66'sd536870912) >>> 30;
        if (q > 66'sd2147483647) return 32'sh7fffffff;
        if (q < -66'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    function automatic logic [23:0] scale_sample(input logic signed [23:0] s,
                                                 input logic signed [31:0] g);
        logic signed [65:0] ws, wg, q;
        ws = 66'(s);
        wg = 66'(g);
        q = (ws * wg + 66'sd536870912) >>> 30;
        if (q > 66'sd8388607) return SAMPLE_MAX;
        if (q < -66'sd8388608) return SAMPLE_MIN;
        return q[23:0];
    endfunction

    function automatic void rotate_phase();
        logic signed [65:0] wc, ws, wx, wy;
        wc = 66'(coef_cos);
        ws = 66'(coef_sin);
        wx = 66'(phase_x);
        wy = 66'(phase_y);
        phase_x = q30_to_phase(wc * wx - ws * wy);
        phase_y = q30_to_phase(ws * wx + wc * wy);
    endfunction

    function automatic lfo_result_t advance_lfo(input lfo_frame_t f);
        lfo_result_t res;
        logic signed [31:0] gain[4];
        res = '0;
        res.osc_r = phase_x;
        res.osc_q = phase_y;
        case (f.cmd)
            CMD_OSC: rotate_phase();
            CMD_ENV: begin
                gain[0] = (phase_x > 0) ? phase_x : 32'sd0;
                gain[1] = (phase_x < 0) ? phase_x : 32'sd0;
                gain[2] = (phase_y > 0) ? phase_y : 32'sd0;
                gain[3] = (phase_y < 0) ? phase_y : 32'sd0;
                for (int i = 0; i < 4; i++) begin
                    res.l[i] = scale_sample(f.l[i], gain[i]);
                    res.r[i] = scale_sample(f.r[i], gain[i]);
                end
                rotate_phase();
                res.flags = {phase_y < 0, phase_y > 0, phase_x < 0, phase_x > 0};
            end
            CMD_LOAD: begin
                phase_x = f.lx;
                phase_y = f.ly;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        lfo_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.l = {m_out_l3, m_out_l2, m_out_l1, m_out_l0};
            got.r = {m_out_r3, m_out_r2, m_out_r1, m_out_r0};
            got.osc_r = m_osc_r;
            got.osc_q = m_osc_q;
            got.flags = m_active_flags;
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transaction with nothing expected", $time);
            end else begin
                want = due_results.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got.l[i] !== want.l[i]) begin
                        mismatches++;
                        $display("%0t: out_l%0d expected %0d got %0d", $time, i,
                                 $signed(want.l[i]), $signed(got.l[i]));
                    end
                    if (got.r[i] !== want.r[i]) begin
                        mismatches++;
                        $display("%0t: out_r%0d expected %0d got %0d", $time, i,
                                 $signed(want.r[i]), $signed(got.r[i]));
                    end
                end
                if (got.osc_r !== want.osc_r) begin
                    mismatches++;
                    $display("%0t: osc_r expected %0d got %0d", $time,
                             $signed(want.osc_r), $signed(got.osc_r));
                end
                if (got.osc_q !== want.osc_q) begin
                    mismatches++;
                    $display("%0t: osc_q expected %0d got %0d", $time,
                             $signed(want.osc_q), $signed(got.osc_q));
                end
                if (got.flags !== want.flags) begin
                    mismatches++;
                    $display("%0t: active_flags expected %b got %b", $time,
                             want.flags, got.flags);
                end
            end
        end
    end

    function automatic lfo_frame_t make_frame(input logic [1:0] cmd,
                                              input logic [23:0] ls, input logic [23:0] rs,
                                              input logic [31:0] lx, input logic [31:0] ly);
        lfo_frame_t f;
        f.cmd = cmd;
        f.l = {4{ls}};
        f.r = {4{rs}};
        f.lx = lx;
        f.ly = ly;
        return f;
    endfunction

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return 24'd0;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_q30();
        longint v;
        case ($urandom_range(9))
            0: return Q30_ONE;
            1: return Q30_MINUS_ONE;
            2: return 32'd0;
            default: begin
                v = longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824;
                return v[31:0];
            end
        endcase
    endfunction

    task automatic send_frame(input lfo_frame_t f);
        while ($urandom_range(99) < stall_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= f.cmd;
        {s_in_l3, s_in_l2, s_in_l1, s_in_l0} <= f.l;
        {s_in_r3, s_in_r2, s_in_r1, s_in_r0} <= f.r;
        s_load_x <= f.lx;
        s_load_y <= f.ly;
        do @(posedge aclk); while (!s_ready);
        due_results.push_back(advance_lfo(f));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_coeffs(input logic [31:0] c, input logic [31:0] s);
        cfg_we <= 1'b1;
        cfg_idx <= REG_ROT_COS;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_idx <= REG_ROT_SIN;
        cfg_wdata <= s;
        @(posedge aclk);
        cfg_we <= 1'b0;
        coef_cos = c;
        coef_sin = s;
    endtask

    task automatic test_reset_defaults();
        send_frame(make_frame(CMD_OSC, 24'd0, 24'd0, 32'd0, 32'd0));
        send_frame(make_frame(CMD_ENV, SAMPLE_MAX, SAMPLE_MAX, 32'd0, 32'd0));
        send_frame(make_frame(CMD_ENV, SAMPLE_MIN, SAMPLE_MIN, 32'd0, 32'd0));
        send_frame(make_frame(CMD_ENV, 24'd0, 24'hffffff, 32'd0, 32'd0));
        send_frame(make_frame(CMD_LOAD, 24'd0, 24'd0, Q30_ONE, 32'd0));
        send_frame(make_frame(CMD_ENV, SAMPLE_MAX, SAMPLE_MIN, 32'd0, 32'd0));
        send_frame(make_frame(CMD_LOAD, 24'd0, 24'd0, Q30_MINUS_ONE, Q30_MINUS_ONE));
        send_frame(make_frame(CMD_ENV, SAMPLE_MIN, SAMPLE_MAX, 32'd0, 32'd0));
        send_frame(make_frame(CMD_LOAD, 24'd0, 24'd0, 32'd0, 32'd0));
        send_frame(make_frame(CMD_ENV, SAMPLE_MAX, SAMPLE_MIN, 32'd0, 32'd0));
        send_frame(make_frame(CMD_UNUSED, SAMPLE_MAX, SAMPLE_MIN, Q30_ONE, Q30_ONE));
        send_frame(make_frame(CMD_LOAD, 24'd0, 24'd0, Q30_ONE, Q30_MINUS_ONE));
        send_frame(make_frame(CMD_UNUSED, 24'd0, 24'd0, 32'd0, 32'd0));
        send_frame(make_frame(CMD_OSC, 24'd0, 24'd0, 32'd0, 32'd0));
        wait_idle();
    endtask

    // Drive the phase past unity so both the rotation and the sample scaling clamp.
    task automatic test_saturation();
        write_coeffs(Q30_ONE, Q30_ONE);
        send_frame(make_frame(CMD_LOAD, 24'd0, 24'd0, Q30_ONE, Q30_ONE));
        send_frame(make_frame(CMD_OSC, 24'd0, 24'd0, 32'd0, 32'd0));
        send_frame(make_frame(CMD_ENV, SAMPLE_MAX, SAMPLE_MIN, 32'd0, 32'd0));
        send_frame(make_frame(CMD_LOAD, 24'd0, 24'd0, Q30_MINUS_ONE, Q30_ONE));
        send_frame(make_frame(CMD_OSC, 24'd0, 24'd0, 32'd0, 32'd0));
        send_frame(make_frame(CMD_ENV, SAMPLE_MAX, SAMPLE_MIN, 32'd0, 32'd0));
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic [31:0] cos_set[6];
        logic [31:0] sin_set[6];
        lfo_frame_t f;
        int pick;
        cos_set = '{Q30_ONE, Q30_MINUS_ONE, 32'd0, 32'd0, Q30_MINUS_ONE, Q30_ONE};
        sin_set = '{32'd0, 32'd0, Q30_ONE, Q30_MINUS_ONE, Q30_MINUS_ONE, Q30_ONE};
        for (int p = 0; p < 12; p++) begin
            if (p < 6) write_coeffs(cos_set[p], sin_set[p]);
            else write_coeffs(pick_q30(), pick_q30());
            stall_pct = (p == 7) ? 0 : 22;
            for (int n = 0; n < 96; n++) begin
                pick = $urandom_range(99);
                for (int i = 0; i < 4; i++) begin
                    f.l[i] = pick_sample();
                    f.r[i] = pick_sample();
                end
                f.lx = pick_q30();
                f.ly = pick_q30();
                if (pick < 40) f.cmd = CMD_ENV;
                else if (pick < 78) f.cmd = CMD_OSC;
                else if (pick < 95) f.cmd = CMD_LOAD;
                else f.cmd = CMD_UNUSED;
                send_frame(f);
            end
            wait_idle();
        end
        stall_pct = 22;
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= REG_ROT_COS;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_cmd <= CMD_OSC;
        {s_in_l3, s_in_l2, s_in_l1, s_in_l0} <= '0;
        {s_in_r3, s_in_r2, s_in_r1, s_in_r0} <= '0;
        s_load_x <= '0;
        s_load_y <= '0;
        m_ready <= 1'b0;
        mismatches = 0;
        cycle_count = 0;
        stall_pct = 22;
        coef_cos = ROT_COS_RESET;
        coef_sin = ROT_SIN_RESET;
        phase_x = PHASE_X_RESET;
        phase_y = PHASE_Y_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_saturation();
        test_random_phases();

        wait_idle();
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
